@@ hdl/assert_macros.svh @@
// assertion helpers for the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication checked on the following cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/dmdp_pkg.sv @@
`timescale 1ns / 1ps

package dmdp_pkg;

  localparam int COEF_W     = 30;
  localparam int RES_W      = 30;
  localparam int MOD_W      = 31;
  localparam int HIGH_W     = 64;
  localparam int DIV_W      = 64;
  localparam int STEP_CNT_W = $clog2(DIV_W);
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 64;

  localparam logic [MOD_W-1:0]      MOD_MAX   = MOD_W'(1) << RES_W;
  localparam logic [MOD_W-1:0]      MOD_MIN   = MOD_W'(2);
  localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(DIV_W - 1);

  typedef enum logic [0:0] {
    REG_MODULUS       = 1'b0,
    REG_SPLIT_RESIDUE = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_DRAIN,
    ST_MOD_HIGH,
    ST_MUL,
    ST_LOAD_LOW,
    ST_MOD_LOW,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic mod_load_high;
    logic mod_load_low;
    logic mod_step;
    logic mul;
    logic out_load;
    logic acc_clear;
  } dmdp_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } dmdp_sts_t;

endpackage

@@ hdl/dmdp_mod_unit.sv @@
`timescale 1ns / 1ps

module dmdp_mod_unit import dmdp_pkg::*; (
  input  logic             clk,
  input  logic             load,
  input  logic             step,
  input  logic [DIV_W-1:0] dividend,
  input  logic [MOD_W-1:0] p,
  output logic [RES_W-1:0] residue
);

  logic [DIV_W-1:0] dividend_shift;
  logic [RES_W-1:0] remainder;
  logic [MOD_W-1:0] trial;
  logic [MOD_W-1:0] diff;

  // restoring remainder, one dividend bit per step, msb first
  assign trial = {remainder, dividend_shift[DIV_W-1]};
  assign diff  = trial - p;

  always_ff @(posedge clk) begin
    if (load) begin
      dividend_shift <= dividend;
      remainder      <= '0;
    end else if (step) begin
      dividend_shift <= {dividend_shift[DIV_W-2:0], 1'b0};
      remainder      <= (trial >= p) ? diff[RES_W-1:0] : trial[RES_W-1:0];
    end
  end

  assign residue = remainder;

endmodule

@@ hdl/dmdp_datapath.sv @@
`timescale 1ns / 1ps

module dmdp_datapath import dmdp_pkg::*; #(
  parameter int SPLIT_BITS = 45,
  parameter int COEF_BITS  = 30
) (
  input  logic              clk,
  input  logic              rst,
  input  dmdp_cmd_t         cmd,
  output dmdp_sts_t         sts,
  input  logic [COEF_W-1:0] coef_first,
  input  logic [COEF_W-1:0] coef_second,
  input  logic [COEF_W-1:0] coef_shared,
  input  logic              cfg_wr_en,
  input  logic [0:0]        cfg_index,
  input  logic [MOD_W-1:0]  cfg_data,
  output logic [RES_W-1:0]  dot_first,
  output logic [RES_W-1:0]  dot_second
);

  localparam int PROD_W  = 2 * COEF_BITS;
  localparam int SUM_W   = ((SPLIT_BITS > PROD_W) ? SPLIT_BITS : PROD_W) + 1;
  localparam int CARRY_W = SUM_W - SPLIT_BITS;

  logic [MOD_W-1:0]      modulus;
  logic [RES_W-1:0]      split_residue;
  logic [MOD_W-1:0]      p_eff;

  logic [PROD_W-1:0]     prod_first;
  logic [PROD_W-1:0]     prod_second;
  logic                  prod_valid;
  logic [SUM_W-1:0]      sum_first;
  logic [SUM_W-1:0]      sum_second;
  logic [SPLIT_BITS-1:0] low_first;
  logic [SPLIT_BITS-1:0] low_second;
  logic [CARRY_W-1:0]    carry_first;
  logic [CARRY_W-1:0]    carry_second;
  logic                  carry_valid;
  logic [HIGH_W-1:0]     high_first;
  logic [HIGH_W-1:0]     high_second;

  logic [2*RES_W-1:0]    fold_first;
  logic [2*RES_W-1:0]    fold_second;
  logic [DIV_W-1:0]      dividend_first;
  logic [DIV_W-1:0]      dividend_second;
  logic [RES_W-1:0]      res_first;
  logic [RES_W-1:0]      res_second;
  logic                  mod_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus       <= MOD_MIN;
      split_residue <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MODULUS:       modulus       <= cfg_data;
        REG_SPLIT_RESIDUE: split_residue <= cfg_data[RES_W-1:0];
      endcase
    end
  end

  assign p_eff = (modulus > MOD_MAX) ? MOD_MAX : modulus;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid  <= 1'b0;
      carry_valid <= 1'b0;
    end else begin
      prod_valid  <= cmd.accept;
      carry_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      prod_first  <= coef_first[COEF_BITS-1:0] * coef_shared[COEF_BITS-1:0];
      prod_second <= coef_second[COEF_BITS-1:0] * coef_shared[COEF_BITS-1:0];
    end
  end

  assign sum_first  = SUM_W'(low_first) + SUM_W'(prod_first);
  assign sum_second = SUM_W'(low_second) + SUM_W'(prod_second);

  // bits above the split are registered and reach the high part in the cycle after the low add
  always_ff @(posedge clk) begin
    if (prod_valid) begin
      carry_first  <= sum_first[SUM_W-1:SPLIT_BITS];
      carry_second <= sum_second[SUM_W-1:SPLIT_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.acc_clear) begin
      low_first   <= '0;
      low_second  <= '0;
      high_first  <= '0;
      high_second <= '0;
    end else begin
      if (prod_valid) begin
        low_first  <= sum_first[SPLIT_BITS-1:0];
        low_second <= sum_second[SPLIT_BITS-1:0];
      end
      if (carry_valid) begin
        high_first  <= high_first + HIGH_W'(carry_first);
        high_second <= high_second + HIGH_W'(carry_second);
      end
    end
  end

  assign sts.pipe_busy = prod_valid | carry_valid;

  // first pass reduces the high part, second pass low + weight * (high mod p)
  assign mod_load        = cmd.mod_load_high | cmd.mod_load_low;
  assign dividend_first  = cmd.mod_load_high ? high_first
                                             : DIV_W'(fold_first) + DIV_W'(low_first);
  assign dividend_second = cmd.mod_load_high ? high_second
                                             : DIV_W'(fold_second) + DIV_W'(low_second);

  dmdp_mod_unit u_mod_first (
    .clk      (clk),
    .load     (mod_load),
    .step     (cmd.mod_step),
    .dividend (dividend_first),
    .p        (p_eff),
    .residue  (res_first)
  );

  dmdp_mod_unit u_mod_second (
    .clk      (clk),
    .load     (mod_load),
    .step     (cmd.mod_step),
    .dividend (dividend_second),
    .p        (p_eff),
    .residue  (res_second)
  );

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      fold_first  <= split_residue * res_first;
      fold_second <= split_residue * res_second;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      dot_first  <= (modulus < MOD_MIN) ? '0 : res_first;
      dot_second <= (modulus < MOD_MIN) ? '0 : res_second;
    end
  end

endmodule

@@ hdl/dmdp_ctrl.sv @@
`timescale 1ns / 1ps

module dmdp_ctrl import dmdp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_last,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output dmdp_cmd_t cmd,
  input  dmdp_sts_t sts
);

  state_t                state;
  state_t                state_next;
  logic [STEP_CNT_W-1:0] step_cnt;
  logic [STEP_CNT_W-1:0] step_cnt_next;
  logic                  out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACCUM;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step_cnt  <= step_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state)
      ST_ACCUM: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_last) state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          cmd.mod_load_high = 1'b1;
          step_cnt_next     = '0;
          state_next        = ST_MOD_HIGH;
        end
      end
      ST_MOD_HIGH: begin
        cmd.mod_step  = 1'b1;
        step_cnt_next = step_cnt + STEP_CNT_W'(1);
        if (step_cnt == LAST_STEP) state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_LOAD_LOW;
      end
      ST_LOAD_LOW: begin
        cmd.mod_load_low = 1'b1;
        step_cnt_next    = '0;
        state_next       = ST_MOD_LOW;
      end
      ST_MOD_LOW: begin
        cmd.mod_step  = 1'b1;
        step_cnt_next = step_cnt + STEP_CNT_W'(1);
        if (step_cnt == LAST_STEP) state_next = ST_OUT;
      end
      ST_OUT: begin
        // wait for the output register to free up
        if (!out_valid || out_ready) begin
          cmd.out_load  = 1'b1;
          cmd.acc_clear = 1'b1;
          state_next    = ST_ACCUM;
        end
      end
      default: state_next = ST_ACCUM;
    endcase
  end

  always_comb begin
    if (cmd.out_load) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

endmodule

@@ hdl/dual_modular_dot_product.sv @@
// channel    dir  handshake                      payload
// s_axis     in   s_axis_tvalid / s_axis_tready  tdata: coef_first, coef_second,
//                                                coef_shared; tlast: last
// m_axis     out  m_axis_tvalid / m_axis_tready  tdata: dot_first, dot_second
// cfg        in   cfg_wr_en                      cfg_index, cfg_data
//
// one element per cycle while a vector streams in (multiply, low add, high add pipe)
// after the element with tlast the result follows a pipe drain,
// then two 64-step passes of the one-bit-per-cycle remainder units
// input is not taken during that reduction; a held result stalls only the next one
// rst is synchronous and clears control, accumulators and config registers at once
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dual_modular_dot_product import dmdp_pkg::*; #(
  parameter int SPLIT_BITS = 45,
  parameter int COEF_BITS  = 30
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // coef_first [29:0], coef_second [59:30], coef_shared [89:60], zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // dot_first [29:0], dot_second [59:30], zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_wr_en,
  input  logic [0:0]            cfg_index,
  input  logic [MOD_W-1:0]      cfg_data
);

  dmdp_cmd_t        cmd;
  dmdp_sts_t        sts;
  logic [RES_W-1:0] dot_first;
  logic [RES_W-1:0] dot_second;

  dmdp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_last   (s_axis_tlast),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  dmdp_datapath #(
    .SPLIT_BITS (SPLIT_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .coef_first  (s_axis_tdata[COEF_W-1:0]),
    .coef_second (s_axis_tdata[2*COEF_W-1:COEF_W]),
    .coef_shared (s_axis_tdata[3*COEF_W-1:2*COEF_W]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .dot_first   (dot_first),
    .dot_second  (dot_second)
  );

  assign m_axis_tdata = {(OUT_DATA_W - 2*RES_W)'(0), dot_second, dot_first};

  `ASSERT_IMPLIES(a_no_overwrite, clk, rst, cmd.out_load, !m_axis_tvalid || m_axis_tready, "result overwritten while held")
  `ASSERT_IMPLIES(a_drained, clk, rst, cmd.mod_load_high, !sts.pipe_busy, "reduction started before the accumulate pipe drained")
  `ASSERT_IMPLIES(a_no_accept_in_reduce, clk, rst, cmd.accept, !cmd.mod_step && !cmd.mul, "transaction taken during reduction")
  `ASSERT_NEXT(a_stop_after_last, clk, rst, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "input still ready after last element")

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import dmdp_pkg::*;

  localparam int SPLIT = 45;
  localparam int CLEAR_WAIT = 200;
  localparam logic [60:0] LOW_MASK = (61'd1 << SPLIT) - 61'd1;
  localparam logic [COEF_W-1:0] COEF_MAX = '1;

  typedef struct {
    logic [COEF_W-1:0] a1;
    logic [COEF_W-1:0] a2;
    logic [COEF_W-1:0] b;
    logic last;
  } elem_t;

  typedef struct {
    logic [RES_W-1:0] first;
    logic [RES_W-1:0] second;
  } dots_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic cfg_wr_en = 1'b0;
  logic [0:0] cfg_index = REG_MODULUS;
  logic [MOD_W-1:0] cfg_data = '0;

  elem_t pending[$];
  dots_t dots_due[$];

  // accumulators and registers as the block should hold them
  logic [60:0] lo_first = '0;
  logic [60:0] lo_second = '0;
  logic [63:0] hi_first = '0;
  logic [63:0] hi_second = '0;
  logic [MOD_W-1:0] mod_reg = MOD_MIN;
  logic [RES_W-1:0] split_reg = '0;

  logic in_fire = 1'b0;
  int src_idle_pct = 37;
  int sink_idle_pct = 56;
  int errors = 0;
  int n_items = 0;
  int items_pushed = 0;
  int n_vectors = 0;
  int n_results = 0;
  int n_writes = 0;

  dual_modular_dot_product u_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic [63:0] eff_modulus(logic [MOD_W-1:0] m);
    if (m > MOD_MAX) return 64'(MOD_MAX);
    return 64'(m);
  endfunction

  task automatic fold_product(ref logic [60:0] lo, ref logic [63:0] hi,
                              input logic [59:0] prod);
    logic [60:0] s;
    s = lo + 61'(prod);
    hi = hi + 64'(s >> SPLIT);
    lo = s & LOW_MASK;
  endtask

  function automatic logic [RES_W-1:0] reduce_acc(logic [60:0] lo, logic [63:0] hi);
    logic [63:0] p;
    logic [63:0] hr;
    logic [63:0] lr;
    logic [63:0] t;
    p = eff_modulus(mod_reg);
    if (p < 64'd2) return '0;
    // high part reduced first so the weighted term stays below 2^60
    hr = hi % p;
    lr = 64'(lo) % p;
    t = (64'(split_reg) * hr) % p;
    return RES_W'((t + lr) % p);
  endfunction

  function automatic logic [RES_W-1:0] split_for(logic [MOD_W-1:0] m);
    logic [63:0] p;
    p = eff_modulus(m);
    if (p < 64'd2) return '0;
    return RES_W'((64'd1 << SPLIT) % p);
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef();
    int r;
    logic [63:0] p;
    r = $urandom_range(99);
    p = eff_modulus(mod_reg);
    if (r < 10) return COEF_MAX;
    if (r < 18) return '0;
    if (r < 40 && p >= 64'd2) return COEF_W'($urandom_range(32'(p - 64'd1)));
    return COEF_W'($urandom());
  endfunction

  task automatic push_item(logic [COEF_W-1:0] a1, logic [COEF_W-1:0] a2,
                           logic [COEF_W-1:0] b, logic last);
    elem_t it;
    it.a1 = a1;
    it.a2 = a2;
    it.b = b;
    it.last = last;
    pending.push_back(it);
    items_pushed++;
    if (last) n_vectors++;
  endtask

  // waits until every element is taken and every dot product has come back
  task automatic drain();
    while (n_items != items_pushed || dots_due.size() != 0) @(negedge clk);
    repeat (CLEAR_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [MOD_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == REG_MODULUS) mod_reg = value;
    else split_reg = value[RES_W-1:0];
    n_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // driver: holds an element until its transaction completes
  always @(negedge clk) begin
    elem_t it;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        it = pending.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_DATA_W'({it.b, it.a2, it.a1});
        s_axis_tlast <= it.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // monitor: predicts on each input transaction, checks each output transaction
  always @(posedge clk) begin
    logic [COEF_W-1:0] a1;
    logic [COEF_W-1:0] a2;
    logic [COEF_W-1:0] b;
    dots_t want;
    dots_t got;
    in_fire <= s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      a1 = s_axis_tdata[COEF_W-1:0];
      a2 = s_axis_tdata[2*COEF_W-1:COEF_W];
      b = s_axis_tdata[3*COEF_W-1:2*COEF_W];
      fold_product(lo_first, hi_first, {30'b0, a1} * {30'b0, b});
      fold_product(lo_second, hi_second, {30'b0, a2} * {30'b0, b});
      n_items++;
      if (s_axis_tlast) begin
        want.first = reduce_acc(lo_first, hi_first);
        want.second = reduce_acc(lo_second, hi_second);
        dots_due.push_back(want);
        lo_first = '0;
        hi_first = '0;
        lo_second = '0;
        hi_second = '0;
      end
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.first = m_axis_tdata[RES_W-1:0];
      got.second = m_axis_tdata[2*RES_W-1:RES_W];
      if (dots_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h / %h",
                 $realtime, got.first, got.second);
      end else begin
        want = dots_due.pop_front();
        n_results++;
        if (got.first !== want.first) begin
          errors++;
          $display("%0t: dot_first mismatch, expected %h, actual %h",
                   $realtime, want.first, got.first);
        end
        if (got.second !== want.second) begin
          errors++;
          $display("%0t: dot_second mismatch, expected %h, actual %h",
                   $realtime, want.second, got.second);
        end
      end
    end
  end

  initial begin
    logic [MOD_W-1:0] m;
    logic [MOD_W-1:0] sr;
    int target;
    int count;
    int len;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // reset settings: modulus 2, no weight on the high part
    push_item(COEF_MAX, COEF_MAX, COEF_MAX, 1'b1);
    push_item('0, '0, '0, 1'b1);
    drain();

    write_reg(REG_MODULUS, 31'd1073741789);
    write_reg(REG_SPLIT_RESIDUE, MOD_W'(split_for(31'd1073741789)));
    push_item(COEF_MAX, COEF_MAX, COEF_MAX, 1'b1);
    push_item(COEF_MAX, '0, COEF_MAX, 1'b1);
    push_item('0, COEF_MAX, 30'd1, 1'b1);
    // a run of full products carries into the high part
    for (int i = 0; i < 8; i++) push_item(COEF_MAX, COEF_MAX, COEF_MAX, i == 7);
    push_item(30'h2AAAAAAA, 30'h15555555, 30'h3FFFFFFF, 1'b0);
    push_item(30'h15555555, 30'h2AAAAAAA, 30'h2AAAAAAA, 1'b1);
    drain();

    write_reg(REG_MODULUS, MOD_MAX);
    write_reg(REG_SPLIT_RESIDUE, '0);
    for (int i = 0; i < 4; i++) push_item(COEF_MAX, COEF_MAX, COEF_MAX, i == 3);

    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        src_idle_pct = 56;
        sink_idle_pct = 37;
      end else if (ph == 6) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      drain();
      target = 130;
      case (ph)
        0: begin
          m = MOD_W'($urandom_range(32'(MOD_MAX), 2));
          sr = MOD_W'(split_for(m));
        end
        1: begin
          // above the largest modulus; weight written with its top bit set
          m = '1;
          sr = MOD_W'($urandom()) | (MOD_W'(1) << RES_W);
        end
        2: begin
          m = 31'd3;
          sr = MOD_W'(COEF_MAX);
        end
        3: begin
          m = MOD_W'($urandom_range(1000, 2));
          sr = MOD_W'(split_for(m));
        end
        4: begin
          m = '0;
          sr = MOD_W'($urandom());
          target = 40;
        end
        5: begin
          m = MOD_MAX;
          sr = '0;
        end
        6: begin
          m = MOD_W'($urandom());
          sr = MOD_W'($urandom());
        end
        7: begin
          m = 31'd1;
          sr = MOD_W'($urandom());
          target = 40;
        end
        default: begin
          m = MOD_W'($urandom_range(32'(MOD_MAX), 32'(MOD_MAX) >> 1));
          sr = MOD_W'(split_for(m));
        end
      endcase
      write_reg(REG_MODULUS, m);
      write_reg(REG_SPLIT_RESIDUE, sr);
      count = 0;
      while (count < target) begin
        // mostly short vectors, now and then a long one
        len = ($urandom_range(9) == 0) ? $urandom_range(150, 20) : $urandom_range(10, 1);
        for (int i = 0; i < len; i++) push_item(pick_coef(), pick_coef(), pick_coef(), i == len - 1);
        count += len;
      end
    end
    drain();

    $display("%0d elements in %0d vectors, %0d dot product pairs checked, %0d mismatches",
             n_items, n_vectors, n_results, errors);
    $display("%0d register writes: moduli 0, 1, 3, up to and above 2^30, under three stall mixes",
             n_writes);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/dmdp_pkg.sv
hdl/dmdp_mod_unit.sv
hdl/dmdp_datapath.sv
hdl/dmdp_ctrl.sv
hdl/dual_modular_dot_product.sv
bench/tb_top.sv
